### hw/rtl/quantized_sync_pattern_search_defines.svh
// Assertion macros shared by the sync search RTL.
`ifndef QUANTIZED_SYNC_PATTERN_SEARCH_DEFINES_SVH
`define QUANTIZED_SYNC_PATTERN_SEARCH_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define QSPS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("qsps: same-cycle check failed");

// Next-cycle implication, checked on aclk outside reset.
`define QSPS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("qsps: next-cycle check failed");

`endif

### hw/rtl/qsps_pkg.sv
package qsps_pkg;

    // Segment and pattern geometry
    localparam int SEG_LEN    = 5;
    localparam int PAT_LEN    = 16;
    localparam int HIST_DEPTH = SEG_LEN * (PAT_LEN - 1) + 1;
    localparam int SPAN       = SEG_LEN * PAT_LEN;

    // Field and datapath widths
    localparam int SMP_W     = 16;
    localparam int SUM_W     = 20;
    localparam int DVD_W     = 20;
    localparam int DIVISOR_W = 18;
    localparam int HOLD_W    = 20;
    localparam int IDX_W     = 32;
    localparam int OUT_W     = 40;

    // Divider sequencing: one quotient bit per step
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // Register map (index = paddr[3:2])
    localparam logic [1:0] REG_QUANT_STEP   = 2'd0;
    localparam logic [1:0] REG_SYNC_PATTERN = 2'd1;
    localparam logic [1:0] REG_HOLDOFF_LEN  = 2'd2;

    localparam logic [DIVISOR_W-1:0] QUANT_STEP_RST   = 18'd131072;
    localparam logic [PAT_LEN-1:0]   SYNC_PATTERN_RST = 16'd30111;
    localparam logic [HOLD_W-1:0]    HOLDOFF_LEN_RST  = 20'd65615;

    // Divider request and status
    typedef struct packed {
        logic                 start;
        logic [DVD_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
        logic parity;
    } div_stat_t;

endpackage

### hw/rtl/qsps_div.sv
module qsps_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  qsps_pkg::div_ctrl_t ctrl,
    output qsps_pkg::div_stat_t stat
);

    logic                           busy_reg, busy_next;
    logic [qsps_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic                           parity_reg, parity_next;
    logic [qsps_pkg::DVD_W-1:0]     dvd_reg, dvd_next;
    logic [qsps_pkg::DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic [qsps_pkg::DIVISOR_W-1:0] rem_reg, rem_next;

    logic [qsps_pkg::DIVISOR_W:0]   trial;
    logic [qsps_pkg::DIVISOR_W:0]   diff;
    logic                           qbit;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, dvd_reg[qsps_pkg::DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign qbit  = (trial >= {1'b0, dsr_reg});

    // Sequence the steps
    always_comb begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        parity_next = parity_reg;
        dvd_next    = dvd_reg;
        dsr_next    = dsr_reg;
        rem_next    = rem_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = qsps_pkg::CNT_W'(qsps_pkg::DIV_STEPS);
            dvd_next  = ctrl.dividend;
            dsr_next  = ctrl.divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[qsps_pkg::DVD_W-2:0], 1'b0};
            rem_next = qbit ? diff[qsps_pkg::DIVISOR_W-1:0] : trial[qsps_pkg::DIVISOR_W-1:0];
            // The last step yields the quotient LSB
            if (cnt_reg == qsps_pkg::CNT_W'(1)) begin
                busy_next   = 1'b0;
                done_next   = 1'b1;
                parity_next = qbit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        parity_reg <= parity_next;
        dvd_reg    <= dvd_next;
        dsr_reg    <= dsr_next;
        rem_reg    <= rem_next;
    end

    assign stat.done   = done_reg;
    assign stat.parity = parity_reg;

endmodule

### hw/rtl/quantized_sync_pattern_search.sv
// Sync pattern search over quantized five-sample segment sums. Each input
// transaction carries one signed 16-bit sample; each produces exactly one
// result transaction with sync_found and, on a hit, the index of the first
// sync sample (sync_start, zero otherwise). Each sample passes through the
// sequencer states in order: IDLE takes it and updates the running sum, PREP
// forms the dividend, DIV runs the bit-serial restoring divider and DONE
// tests the pattern and loads the result register, waiting while that
// register is still full. s_tready is high only while the sequencer is idle;
// a result may wait in the output register while the next sample is accepted.
// Registers sit on the APB port at 0x0 quant_step, 0x4 sync_pattern, 0x8
// holdoff_len and should be written only while no sample is in flight.
`include "quantized_sync_pattern_search_defines.svh"

module quantized_sync_pattern_search (
    input  logic        aclk,
    input  logic        aresetn,
    // Sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] sync_found, [32:1] sync_start, [39:33] zero
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [qsps_pkg::DIVISOR_W-1:0]  quant_step_reg;
    logic [qsps_pkg::PAT_LEN-1:0]    sync_pattern_reg;
    logic [qsps_pkg::HOLD_W-1:0]     holdoff_len_reg;

    logic signed [qsps_pkg::SMP_W-1:0] recent_reg [qsps_pkg::SEG_LEN];
    logic signed [qsps_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [qsps_pkg::HIST_DEPTH-1:0]   hist_reg, hist_next;
    logic [qsps_pkg::IDX_W-1:0]        index_reg;
    logic [qsps_pkg::HOLD_W-1:0]       holdoff_reg, holdoff_next;
    logic                              parity_reg;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [qsps_pkg::OUT_W-1:0]        m_tdata_reg;

    qsps_pkg::div_ctrl_t div_ctrl;
    qsps_pkg::div_stat_t div_stat;

    logic                              in_xact;
    logic                              cfg_wr;
    logic [1:0]                        cfg_idx;
    logic                              finish;
    logic                              match;
    logic                              detect;
    logic [qsps_pkg::IDX_W-1:0]        start_idx;
    logic [qsps_pkg::DIVISOR_W-1:0]    divisor;
    logic signed [qsps_pkg::SUM_W:0]   sum_ext;
    logic [qsps_pkg::SUM_W:0]          neg_adj;
    logic signed [qsps_pkg::SUM_W-1:0] smp_ext;
    logic signed [qsps_pkg::SUM_W-1:0] old_ext;

    // Handshakes
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xact  = s_tvalid && s_tready;
    assign finish   = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = paddr[3:2];
    assign pready   = 1'b1;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quant_step_reg   <= qsps_pkg::QUANT_STEP_RST;
            sync_pattern_reg <= qsps_pkg::SYNC_PATTERN_RST;
            holdoff_len_reg  <= qsps_pkg::HOLDOFF_LEN_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                qsps_pkg::REG_QUANT_STEP:
                    quant_step_reg <= pwdata[qsps_pkg::DIVISOR_W-1:0];
                qsps_pkg::REG_SYNC_PATTERN:
                    sync_pattern_reg <= pwdata[qsps_pkg::PAT_LEN-1:0];
                qsps_pkg::REG_HOLDOFF_LEN:
                    holdoff_len_reg <= pwdata[qsps_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (cfg_idx)
            qsps_pkg::REG_QUANT_STEP:   prdata = 32'(quant_step_reg);
            qsps_pkg::REG_SYNC_PATTERN: prdata = 32'(sync_pattern_reg);
            qsps_pkg::REG_HOLDOFF_LEN:  prdata = 32'(holdoff_len_reg);
            default:                    prdata = '0;
        endcase
    end

    // Running segment sum: add the new sample, drop the oldest
    assign smp_ext  = qsps_pkg::SUM_W'(signed'(s_tdata));
    assign old_ext  = qsps_pkg::SUM_W'(recent_reg[qsps_pkg::SEG_LEN-1]);
    assign sum_next = sum_reg - old_ext + smp_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            for (int i = 0; i < qsps_pkg::SEG_LEN; i++) begin
                recent_reg[i] <= '0;
            end
        end else if (in_xact) begin
            sum_reg       <= sum_next;
            recent_reg[0] <= signed'(s_tdata);
            for (int i = 1; i < qsps_pkg::SEG_LEN; i++) begin
                recent_reg[i] <= recent_reg[i-1];
            end
        end
    end

    // Dividend: floor division of a negative sum uses the ceiling of its magnitude
    assign divisor  = (quant_step_reg == '0) ? qsps_pkg::DIVISOR_W'(1) : quant_step_reg;
    assign sum_ext  = {sum_reg[qsps_pkg::SUM_W-1], sum_reg};
    assign neg_adj  = (qsps_pkg::SUM_W+1)'(-sum_ext)
                    + (qsps_pkg::SUM_W+1)'(divisor) - 1'b1;

    always_comb begin
        div_ctrl.start    = (state_reg == ST_PREP);
        div_ctrl.divisor  = divisor;
        div_ctrl.dividend = sum_reg[qsps_pkg::SUM_W-1] ? neg_adj[qsps_pkg::DVD_W-1:0]
                                                        : qsps_pkg::DVD_W'(sum_reg);
    end

    qsps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .stat    (div_stat)
    );

    // Pattern test on the history with the new parity shifted in
    assign hist_next = {hist_reg[qsps_pkg::HIST_DEPTH-2:0], parity_reg};

    always_comb begin
        match = 1'b1;
        for (int i = 0; i < qsps_pkg::PAT_LEN; i++) begin
            if (hist_next[qsps_pkg::SEG_LEN * (qsps_pkg::PAT_LEN - 1 - i)]
                    != sync_pattern_reg[i]) begin
                match = 1'b0;
            end
        end
    end

    assign detect    = (holdoff_reg == '0) && (index_reg >= qsps_pkg::IDX_W'(qsps_pkg::SPAN))
                     && match;
    assign start_idx = index_reg - qsps_pkg::IDX_W'(qsps_pkg::SPAN - 1);

    // Holdoff: count down, or load after a detected sync
    always_comb begin
        holdoff_next = holdoff_reg;
        if (holdoff_reg != '0) begin
            holdoff_next = holdoff_reg - 1'b1;
        end else if (detect) begin
            holdoff_next = holdoff_len_reg;
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_xact) state_next = ST_PREP;
            ST_PREP: state_next = ST_DIV;
            ST_DIV:  if (div_stat.done) state_next = ST_DONE;
            ST_DONE: if (finish) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register: hold until taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (finish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            hist_reg     <= '0;
            index_reg    <= '0;
            holdoff_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (finish) begin
                hist_reg    <= hist_next;
                index_reg   <= index_reg + 1'b1;
                holdoff_reg <= holdoff_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DIV) && div_stat.done) begin
            parity_reg <= div_stat.parity;
        end
        if (finish) begin
            m_tdata_reg <= {7'b0, detect ? start_idx : qsps_pkg::IDX_W'(0), detect};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `QSPS_ASSERT_IMP(a_nosync_zero_start, m_tvalid && !m_tdata[0], m_tdata[32:1] == '0)
    `QSPS_ASSERT_NXT(a_holdoff_counts, finish && (holdoff_reg != '0), holdoff_reg == $past(holdoff_reg) - 1'b1)
    `QSPS_ASSERT_NXT(a_sync_loads_holdoff, finish && detect, holdoff_reg == $past(holdoff_len_reg))
    `QSPS_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_reg == ST_DIV)

endmodule
